@@ sv/ffoa_pkg.sv @@
// Shared constants, codes and control types of the first-fit offset allocator.
package ffoa_pkg;

	localparam int MAX_LIVE    = 64;
	localparam int OFFSET_BITS = 32;
	localparam int IDX_W       = $clog2(MAX_LIVE);
	localparam int CNT_W       = $clog2(MAX_LIVE + 1);
	localparam int LIVE_W      = 7;
	localparam int STATUS_W    = 3;
	localparam int CMD_W       = 4;

	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL         = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_END_MISMATCH = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ZERO_SIZE    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_RANGE        = 3'd5;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [CMD_W-1:0] CMD_NONE   = 4'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_SCAN   = 4'd2;
	localparam logic [CMD_W-1:0] CMD_MARK   = 4'd3;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 4'd4;
	localparam logic [CMD_W-1:0] CMD_SHIFT  = 4'd5;
	localparam logic [CMD_W-1:0] CMD_INSERT = 4'd6;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 4'd7;
	localparam logic [CMD_W-1:0] CMD_DROP   = 4'd8;
	localparam logic [CMD_W-1:0] CMD_FAIL   = 4'd9;

	typedef struct packed {
		logic [CMD_W-1:0]    code;
		logic [STATUS_W-1:0] fail_code;
	} ffoa_cmd_t;

	typedef struct packed {
		logic is_free;
		logic zero_size;
		logic full;
		logic scan_end;
		logic hit;
		logic range_err;
		logic key_match;
		logic end_match;
		logic shift_last;
		logic remove_last;
	} ffoa_stat_t;

endpackage

@@ sv/ffoa_dp.sv @@
// Datapath of the allocator: live table memory, walk registers and result register.
module ffoa_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            opcode,
	input  logic [ffoa_pkg::OFFSET_BITS-1:0] alloc_size,
	input  logic [ffoa_pkg::OFFSET_BITS-1:0] free_start,
	input  logic [ffoa_pkg::OFFSET_BITS-1:0] free_end,
	input  ffoa_pkg::ffoa_cmd_t             cmd,
	output ffoa_pkg::ffoa_stat_t            stat,
	output logic                            done,
	output logic [ffoa_pkg::STATUS_W-1:0]    status,
	output logic [ffoa_pkg::OFFSET_BITS-1:0] block_start,
	output logic [ffoa_pkg::OFFSET_BITS-1:0] block_end,
	output logic [ffoa_pkg::OFFSET_BITS-1:0] high_water,
	output logic [ffoa_pkg::LIVE_W-1:0]      live_count
);
	import ffoa_pkg::*;

	logic [OFFSET_BITS-1:0] start_mem_q [MAX_LIVE];
	logic [OFFSET_BITS-1:0] end_mem_q   [MAX_LIVE];
	logic [OFFSET_BITS-1:0] rd_start_q;
	logic [OFFSET_BITS-1:0] rd_end_q;

	logic                   op_q;
	logic [OFFSET_BITS-1:0] size_q;
	logic [OFFSET_BITS-1:0] key_start_q;
	logic [OFFSET_BITS-1:0] key_end_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [CNT_W-1:0]       idx_q;
	logic [CNT_W-1:0]       slot_q;
	logic [CNT_W-1:0]       count_q;
	logic [OFFSET_BITS-1:0] peak_q;
	logic                   done_q;
	logic [STATUS_W-1:0]    status_q;
	logic [OFFSET_BITS-1:0] bs_q;
	logic [OFFSET_BITS-1:0] be_q;

	logic [OFFSET_BITS:0]   sum;
	logic [CNT_W-1:0]       idx_next;
	logic [IDX_W-1:0]       rd_addr;
	logic [IDX_W-1:0]       wr_addr;
	logic                   wr_en;
	logic [OFFSET_BITS-1:0] wr_start;
	logic [OFFSET_BITS-1:0] wr_end;

	// End of the candidate block; its top bit means it runs past the address range.
	assign sum      = {1'b0, pos_q} + {1'b0, size_q};
	assign idx_next = idx_q + CNT_W'(1);

	always_comb begin
		rd_addr  = idx_q[IDX_W-1:0];
		wr_en    = 1'b0;
		wr_addr  = idx_q[IDX_W-1:0];
		wr_start = rd_start_q;
		wr_end   = rd_end_q;
		unique case (cmd.code)
			CMD_LOAD: rd_addr = '0;
			CMD_SCAN: rd_addr = idx_next[IDX_W-1:0];
			CMD_MARK: begin
				rd_addr = IDX_W'(count_q - CNT_W'(1));
			end
			CMD_PEEK: rd_addr = idx_next[IDX_W-1:0];
			CMD_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = idx_next[IDX_W-1:0];
				rd_addr = IDX_W'(idx_q - CNT_W'(1));
			end
			CMD_INSERT: begin
				wr_en    = 1'b1;
				wr_addr  = slot_q[IDX_W-1:0];
				wr_start = pos_q;
				wr_end   = sum[OFFSET_BITS-1:0];
			end
			CMD_REMOVE: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[IDX_W-1:0];
				rd_addr = IDX_W'(idx_q + CNT_W'(2));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_mem_q[wr_addr] <= wr_start;
			end_mem_q[wr_addr]   <= wr_end;
		end
		rd_start_q <= start_mem_q[rd_addr];
		rd_end_q   <= end_mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		unique case (cmd.code)
			CMD_LOAD: begin
				op_q        <= opcode;
				size_q      <= alloc_size;
				key_start_q <= free_start;
				key_end_q   <= free_end;
				pos_q       <= '0;
				idx_q       <= '0;
			end
			CMD_SCAN: begin
				pos_q <= rd_end_q;
				idx_q <= idx_next;
			end
			CMD_MARK: begin
				slot_q <= idx_q;
				idx_q  <= count_q - CNT_W'(1);
			end
			CMD_SHIFT:  idx_q <= idx_q - CNT_W'(1);
			CMD_REMOVE: idx_q <= idx_next;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			peak_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (cmd.code)
				CMD_INSERT: begin
					count_q <= count_q + CNT_W'(1);
					done_q  <= 1'b1;
					if (slot_q == count_q && sum[OFFSET_BITS-1:0] > peak_q) begin
						peak_q <= sum[OFFSET_BITS-1:0];
					end
				end
				CMD_DROP: begin
					count_q <= count_q - CNT_W'(1);
					done_q  <= 1'b1;
				end
				CMD_FAIL: done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.code)
			CMD_INSERT: begin
				status_q <= ST_OK;
				bs_q     <= pos_q;
				be_q     <= sum[OFFSET_BITS-1:0];
			end
			CMD_DROP: begin
				status_q <= ST_OK;
				bs_q     <= '0;
				be_q     <= '0;
			end
			CMD_FAIL: begin
				status_q <= cmd.fail_code;
				bs_q     <= '0;
				be_q     <= '0;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.is_free     = (op_q == OP_FREE);
		stat.zero_size   = (size_q == '0);
		stat.full        = (count_q == CNT_W'(MAX_LIVE));
		stat.scan_end    = (idx_q == count_q);
		stat.hit         = (op_q == OP_FREE) ? (rd_start_q >= key_start_q)
		                                     : ({1'b0, rd_start_q} >= sum);
		stat.range_err   = sum[OFFSET_BITS];
		stat.key_match   = (rd_start_q == key_start_q);
		stat.end_match   = (rd_end_q == key_end_q);
		stat.shift_last  = (idx_q == slot_q);
		stat.remove_last = (idx_next == count_q);
	end

	assign done        = done_q;
	assign status      = status_q;
	assign block_start = bs_q;
	assign block_end   = be_q;
	assign high_water  = peak_q;
	assign live_count  = LIVE_W'(count_q);

endmodule

@@ sv/ffoa_ctrl.sv @@
// Controller state machine that sequences the allocator datapath for one request.
module ffoa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  ffoa_pkg::ffoa_stat_t stat,
	output ffoa_pkg::ffoa_cmd_t  cmd,
	output logic                 busy
);
	import ffoa_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_SHIFT  = 3'd3;
	localparam logic [2:0] S_INSERT = 3'd4;
	localparam logic [2:0] S_REMOVE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d       = state_q;
		cmd.code      = CMD_NONE;
		cmd.fail_code = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.code = CMD_LOAD;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!stat.is_free && stat.zero_size) begin
					cmd.code      = CMD_FAIL;
					cmd.fail_code = ST_ZERO_SIZE;
					state_d       = S_IDLE;
				end else if (!stat.is_free && stat.full) begin
					cmd.code      = CMD_FAIL;
					cmd.fail_code = ST_FULL;
					state_d       = S_IDLE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_end) begin
					if (stat.is_free) begin
						cmd.code      = CMD_FAIL;
						cmd.fail_code = ST_NOT_FOUND;
						state_d       = S_IDLE;
					end else if (stat.range_err) begin
						cmd.code      = CMD_FAIL;
						cmd.fail_code = ST_RANGE;
						state_d       = S_IDLE;
					end else begin
						cmd.code = CMD_MARK;
						state_d  = S_INSERT;
					end
				end else if (stat.hit) begin
					if (!stat.is_free) begin
						cmd.code = CMD_MARK;
						state_d  = S_SHIFT;
					end else if (stat.key_match && stat.end_match) begin
						cmd.code = CMD_PEEK;
						state_d  = S_REMOVE;
					end else begin
						cmd.code      = CMD_FAIL;
						cmd.fail_code = stat.key_match ? ST_END_MISMATCH : ST_NOT_FOUND;
						state_d       = S_IDLE;
					end
				end else begin
					cmd.code = CMD_SCAN;
				end
			end
			S_SHIFT: begin
				cmd.code = CMD_SHIFT;
				if (stat.shift_last) begin
					state_d = S_INSERT;
				end
			end
			S_INSERT: begin
				cmd.code = CMD_INSERT;
				state_d  = S_IDLE;
			end
			S_REMOVE: begin
				if (stat.remove_last) begin
					cmd.code = CMD_DROP;
					state_d  = S_IDLE;
				end else begin
					cmd.code = CMD_REMOVE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

@@ sv/first_fit_offset_allocator_unit.sv @@
// Top level of the first-fit offset allocator: controller joined to datapath.
// Sequence: a zero-size or full-table allocate fails before any walk; otherwise the
// walk and the shift or close-up that follows it step through the live entries
// between them, one entry a cycle.
// Throughput: one request at a time; the next is taken in the cycle its result shows.
// Reset clears the live count, the high-water mark and the controller; the table
// itself is not cleared, as only its first live-count entries are ever used.
// The result strobe done lasts one cycle and the receiver cannot stall it.
module first_fit_offset_allocator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             opcode,
	input  logic [ffoa_pkg::OFFSET_BITS-1:0] alloc_size,
	input  logic [ffoa_pkg::OFFSET_BITS-1:0] free_start,
	input  logic [ffoa_pkg::OFFSET_BITS-1:0] free_end,
	output logic                             done,
	output logic [ffoa_pkg::STATUS_W-1:0]    status,
	output logic [ffoa_pkg::OFFSET_BITS-1:0] block_start,
	output logic [ffoa_pkg::OFFSET_BITS-1:0] block_end,
	output logic [ffoa_pkg::OFFSET_BITS-1:0] high_water,
	output logic [ffoa_pkg::LIVE_W-1:0]      live_count
);
	import ffoa_pkg::*;

	// The controller only issues commands and watches status flags; all table
	// storage, the walk pointer, the running gap position and the result
	// register sit in the datapath.
	ffoa_cmd_t  cmd;
	ffoa_stat_t stat;
	logic       busy_int;

	// A request is taken when start is high while the controller is idle.
	ffoa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy_int)
	);

	// The datapath walks the start-sorted table one entry a cycle through a
	// memory with a registered read port, then moves entries up or down one
	// place a cycle to open or close a slot.
	ffoa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.opcode      (opcode),
		.alloc_size  (alloc_size),
		.free_start  (free_start),
		.free_end    (free_end),
		.cmd         (cmd),
		.stat        (stat),
		.done        (done),
		.status      (status),
		.block_start (block_start),
		.block_end   (block_end),
		.high_water  (high_water),
		.live_count  (live_count)
	);

	assign busy = busy_int;

endmodule

@@ dv/tb_first_fit_offset_allocator_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench that drives allocate and free requests into the first-fit offset allocator.
module tb_first_fit_offset_allocator_unit;
	import ffoa_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 11;
	// An allocate is the slowest request: it walks the table and may then shift it.
	localparam int DRAIN_CYCLES = 2 * MAX_LIVE + 16;
	// Around 1650 requests, each with its work and a sender gap, need well under the limit,
	// which allows several times their total.
	localparam int CYCLE_LIMIT  = 1500000;
	localparam int PRINT_LIMIT  = 40;

	typedef logic [OFFSET_BITS-1:0] offset_t;

	// One reply of the allocator, as the table model predicts it.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		offset_t             block_start;
		offset_t             block_end;
		offset_t             high_water;
		logic [LIVE_W-1:0]   live_count;
	} alloc_reply_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                start      = 1'b0;
	logic                opcode     = OP_ALLOC;
	offset_t             alloc_size = '0;
	offset_t             free_start = '0;
	offset_t             free_end   = '0;
	logic                busy;
	logic                done;
	logic [STATUS_W-1:0] status;
	offset_t             block_start;
	offset_t             block_end;
	offset_t             high_water;
	logic [LIVE_W-1:0]   live_count;

	// Our own copy of the live-block table: entries sorted by start, each with its end.
	offset_t      live_lo [MAX_LIVE];
	offset_t      live_hi [MAX_LIVE];
	int unsigned  live_n      = 0;
	offset_t      peak_end    = '0;
	alloc_reply_t reply_queue [$];
	int unsigned  mismatches  = 0;
	int unsigned  cycle_count = 0;

	always #CLK_HALF clk = ~clk;

	first_fit_offset_allocator_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.alloc_size  (alloc_size),
		.free_start  (free_start),
		.free_end    (free_end),
		.done        (done),
		.status      (status),
		.block_start (block_start),
		.block_end   (block_end),
		.high_water  (high_water),
		.live_count  (live_count)
	);

	// Applies one request to the table model and returns the reply that it should give.
	// An allocate scans for the first gap that is wide enough; if none is found the block
	// goes after the last live one, which is the only placement that can run past the
	// address range or raise the high-water mark. A free looks its start up, checks the
	// end and closes the hole. With 32-bit offsets no free can be out of range.
	function automatic alloc_reply_t place_or_release(logic op, offset_t size,
			offset_t lo, offset_t hi);
		alloc_reply_t         r;
		offset_t              pos;
		logic [OFFSET_BITS:0] stop;
		int unsigned          slot;
		logic                 found;
		r     = '0;
		pos   = '0;
		found = 1'b0;
		slot  = live_n;
		if (op == OP_ALLOC) begin
			if (size == '0) begin
				r.status = ST_ZERO_SIZE;
			end else if (live_n >= MAX_LIVE) begin
				r.status = ST_FULL;
			end else begin
				for (int i = 0; i < live_n; i++) begin
					if (!found) begin
						if (live_lo[i] >= pos && live_lo[i] - pos >= size) begin
							slot  = i;
							found = 1'b1;
						end else begin
							pos = live_hi[i];
						end
					end
				end
				stop = {1'b0, pos} + {1'b0, size};
				if (!found && stop[OFFSET_BITS]) begin
					r.status = ST_RANGE;
				end else begin
					if (!found && stop[OFFSET_BITS-1:0] > peak_end) begin
						peak_end = stop[OFFSET_BITS-1:0];
					end
					for (int i = live_n; i > slot; i--) begin
						live_lo[i] = live_lo[i-1];
						live_hi[i] = live_hi[i-1];
					end
					live_lo[slot]  = pos;
					live_hi[slot]  = stop[OFFSET_BITS-1:0];
					live_n++;
					r.status      = ST_OK;
					r.block_start = pos;
					r.block_end   = stop[OFFSET_BITS-1:0];
				end
			end
		end else begin
			for (int i = 0; i < live_n; i++) begin
				if (!found && live_lo[i] >= lo) begin
					slot  = i;
					found = 1'b1;
				end
			end
			if (slot >= live_n || live_lo[slot] != lo) begin
				r.status = ST_NOT_FOUND;
			end else if (live_hi[slot] != hi) begin
				r.status = ST_END_MISMATCH;
			end else begin
				for (int i = slot; i + 1 < live_n; i++) begin
					live_lo[i] = live_lo[i+1];
					live_hi[i] = live_hi[i+1];
				end
				live_n--;
				r.status = ST_OK;
			end
		end
		r.high_water = peak_end;
		r.live_count = live_n[LIVE_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, offset_t got, offset_t want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT) begin
			$display("%0t: mismatch on %s, got %h, expected %h", $time, what, got, want);
		end
	endtask

	// Presents one request and holds it until the unit takes it. Start is left high, so
	// that a caller with another request ready keeps it asserted without a drop.
	task automatic send_request(logic op, offset_t size, offset_t lo, offset_t hi);
		opcode     <= op;
		alloc_size <= size;
		free_start <= lo;
		free_end   <= hi;
		start      <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		reply_queue.push_back(place_or_release(op, size, lo, hi));
	endtask

	// The fields that a request ignores still carry random values.
	task automatic alloc(offset_t size);
		send_request(OP_ALLOC, size, $urandom(), $urandom());
	endtask

	task automatic release_block(offset_t lo, offset_t hi);
		send_request(OP_FREE, $urandom(), lo, hi);
	endtask

	// Idles the sender with the given chance. Gaps are mostly short so that the next
	// request lands at every point of a table walk; now and then one outlasts a request.
	task automatic pause_sender(int unsigned pct);
		int unsigned gap;
		if ($urandom_range(99, 0) < pct) begin
			gap = ($urandom_range(7, 0) == 0) ? $urandom_range(150, 9) : $urandom_range(8, 1);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Frees every live block, in random order, leaving the table empty.
	task automatic release_all(int unsigned idle_pct);
		int unsigned k;
		while (live_n != 0) begin
			k = $urandom_range(live_n - 1, 0);
			release_block(live_lo[k], live_hi[k]);
			pause_sender(idle_pct);
		end
	endtask

	// Most sizes are small, so that the table fills and gaps get reused; a few are zero.
	function automatic offset_t pick_size();
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 3) begin
			return '0;
		end else if (roll < 75) begin
			return $urandom_range(64, 1);
		end
		return $urandom_range(4096, 1);
	endfunction

	// Directed requests: an empty-table free, a zero size, gap reuse at the front, in the
	// middle and too narrow to fit, a wrong end, and starts that match no live block.
	task automatic test_basic_cases();
		release_block('0, '0);
		alloc('0);
		alloc(32'd16);
		alloc(32'd1);
		alloc(32'd32);
		release_block(32'd16, 32'd18);
		release_block(32'd16, 32'd17);
		alloc(32'd2);
		alloc(32'd1);
		release_block('0, 32'd16);
		alloc(32'd8);
		release_block(32'd5, 32'd9);
		release_block('1, '1);
		alloc(32'd8);
		release_block('0, '1);
		release_all(0);
	endtask

	// Fills the table to the last entry, checks that a full table refuses an allocate and
	// that a zero size is still reported as such, reuses the front gap with a whole-table
	// shift, tries a wrong end, frees the last entry and allocates once more, then empties the table.
	task automatic test_fill_and_drain();
		offset_t     sz;
		int unsigned k;
		while (live_n < MAX_LIVE) begin
			alloc($urandom_range(32, 1));
			pause_sender(9);
		end
		alloc($urandom_range(32, 1));
		alloc('0);
		sz = live_hi[0] - live_lo[0];
		release_block(live_lo[0], live_hi[0]);
		alloc(sz);
		k = $urandom_range(MAX_LIVE - 1, 0);
		release_block(live_lo[k], live_hi[k] + 1'b1);
		release_block(live_lo[MAX_LIVE-1], live_hi[MAX_LIVE-1]);
		alloc($urandom_range(64, 1));
		release_all(25);
	endtask

	// Random traffic: allocates and frees, the frees mostly of live blocks with their true
	// ends, some with a damaged start or end, and some noise. The allocate share sets where
	// the live count tends to sit, so that some phases run into the full table.
	task automatic test_random_traffic(int unsigned count, int unsigned idle_pct,
			int unsigned alloc_pct);
		int unsigned k;
		int unsigned roll;
		offset_t     lo;
		offset_t     hi;
		repeat (count) begin
			if ($urandom_range(99, 0) < alloc_pct) begin
				alloc(pick_size());
			end else begin
				roll = $urandom_range(99, 0);
				if (live_n != 0 && roll < 88) begin
					k  = $urandom_range(live_n - 1, 0);
					lo = live_lo[k];
					hi = live_hi[k];
					roll = $urandom_range(99, 0);
					if (roll >= 92) begin
						lo = lo ^ (offset_t'(1) << $urandom_range(OFFSET_BITS - 1, 0));
					end else if (roll >= 80) begin
						hi = hi ^ (offset_t'(1) << $urandom_range(OFFSET_BITS - 1, 0));
					end
					release_block(lo, hi);
				end else begin
					release_block($urandom(), $urandom());
				end
			end
			pause_sender(idle_pct);
		end
	endtask

	// Offsets at the top of the address range. This runs last, since it drives the
	// high-water mark to its maximum, where it then stays.
	task automatic test_offset_limits();
		int unsigned k;
		release_all(0);
		alloc(32'h8000_0000);
		alloc(32'h8000_0001);
		alloc(32'h7FFF_FFFF);
		alloc(32'd1);
		release_block(32'h8000_0000, '1);
		alloc('1);
		release_block('0, 32'h8000_0000);
		alloc('1);
		alloc(32'd1);
		release_block('0, '1);
		repeat (60) begin
			if ($urandom_range(1, 0) == 0) begin
				alloc($urandom());
			end else if (live_n != 0 && $urandom_range(3, 0) != 0) begin
				k = $urandom_range(live_n - 1, 0);
				release_block(live_lo[k], live_hi[k]);
			end else begin
				release_block($urandom(), $urandom());
			end
			pause_sender(9);
		end
	endtask

	// Each reply is compared with the oldest outstanding prediction. The strobe lasts
	// one cycle, so it is sampled at every rising edge.
	always @(posedge clk) begin
		alloc_reply_t want;
		if (done === 1'b1) begin
			if (reply_queue.size() == 0) begin
				report_mismatch("reply with no request outstanding", block_start, '0);
			end else begin
				want = reply_queue.pop_front();
				if (status !== want.status) begin
					report_mismatch("status", offset_t'(status), offset_t'(want.status));
				end
				if (block_start !== want.block_start) begin
					report_mismatch("block_start", block_start, want.block_start);
				end
				if (block_end !== want.block_end) begin
					report_mismatch("block_end", block_end, want.block_end);
				end
				if (high_water !== want.high_water) begin
					report_mismatch("high_water", high_water, want.high_water);
				end
				if (live_count !== want.live_count) begin
					report_mismatch("live_count", offset_t'(live_count),
						offset_t'(want.live_count));
				end
			end
		end
	end

	// Guards against a hang anywhere in the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_basic_cases();
		test_fill_and_drain();
		// Back-to-back requests, then a mostly idle sender, then a lightly idle one
		// that pushes into the full table, then back-to-back with frees dominating.
		test_random_traffic(350, 0, 60);
		test_random_traffic(350, 55, 45);
		test_random_traffic(350, 9, 80);
		test_random_traffic(350, 0, 35);
		test_offset_limits();
		start <= 1'b0;
		while (reply_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
